/* rtl/sm3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3 package
// Shared types, constants and bit functions for the sm3 hash unit.
// ----------------------------------------------------------------------------
package sm3_pkg;

	// initial chaining value
	localparam logic [31:0] SM3_IV [8] = '{
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	// round constants for the first sixteen rounds and for the rest
	localparam logic [31:0] SM3_T_LO = 32'h79cc4519;
	localparam logic [31:0] SM3_T_HI = 32'h7a879d8a;

	// padding
	localparam logic [7:0] PAD_MARK    = 8'h80;
	localparam logic [5:0] PAD_LEN_POS = 6'd56;
	localparam logic [5:0] FILL_LAST   = 6'd63;

	// byte write into the block buffer
	typedef struct packed {
		logic       en;
		logic [3:0] idx;
		logic [1:0] lane;
		logic [7:0] data;
	} sm3_wr_t;

	// sequencer to compression unit
	typedef struct packed {
		logic start;
		logic init;
	} sm3_rctl_t;

	// compression unit status
	typedef struct packed {
		logic shift;
		logic done;
	} sm3_rst_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] tmp;
		tmp = {x, x} << n;
		return tmp[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	// rotated round constant for round j
	function automatic logic [31:0] t_rot(input logic [5:0] j);
		logic [31:0] t;
		t = (j[5:4] == 2'b00) ? SM3_T_LO : SM3_T_HI;
		return rotl(t, j[4:0]);
	endfunction

endpackage

/* rtl/sm3_hash_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3 hash unit
// SM3 digest of a byte message delivered as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Input channel: data_word with byte_count valid leading bytes (above four
// counts as four) and last_word on the final item. in_stall is high while
// an item is being worked on; one item at a time is taken.
// Each accepted item has its valid bytes written into the block buffer by
// the packer, one byte a cycle except while a compression runs. Every 64th
// byte starts the round unit: 64 rounds, then a fold into the chaining value.
// On last_word the padding (0x80, zeros to byte 56, eight length bytes)
// goes through the same byte path, one byte a cycle outside compressions,
// then one or two compressions, then eight digest words, most significant
// first, with digest_last on the eighth. The chaining value then returns to
// the initial value. A new item may be taken as soon as the last digest
// word sits in the output register.
// The output register holds its word while out_stall is high; the block
// waits on it. Reset clears all control state and loads the initial value.
// ----------------------------------------------------------------------------
module sm3_hash_unit
	import sm3_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        digest_last
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DATA, ST_MARK, ST_ZERO, ST_LEN, ST_COMP, ST_OUT
	} state_t;

	state_t      state_q, ret_q, nxt;
	logic [31:0] word_q;
	logic [2:0]  cnt_q;
	logic        last_q;
	logic [5:0]  fill_q;
	logic [63:0] bitlen_q;
	logic [63:0] len_q;
	logic [2:0]  lcnt_q;
	logic [2:0]  oidx_q;
	logic        out_valid_q;
	logic        digest_last_q;
	logic [31:0] digest_word_q;

	logic [2:0]  sat_cnt;
	logic        put_en;
	logic [7:0]  put_byte;
	logic        blk_full;
	logic        out_free;
	logic        out_load;
	sm3_wr_t     wr;
	sm3_rctl_t   rctl;
	sm3_rst_t    rstat;
	logic [31:0] w_j, wp_j, cv_word;

	assign sat_cnt  = (byte_count > 3'd4) ? 3'd4 : byte_count;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_OUT) && out_free;

	// byte source per state
	always_comb begin
		put_en   = 1'b0;
		put_byte = 8'd0;
		nxt      = state_q;
		case (state_q)
			ST_DATA: begin
				put_en   = 1'b1;
				put_byte = word_q[31:24];
				nxt      = (cnt_q == 3'd1) ? (last_q ? ST_MARK : ST_IDLE) : ST_DATA;
			end
			ST_MARK: begin
				put_en   = 1'b1;
				put_byte = PAD_MARK;
				nxt      = ST_ZERO;
			end
			ST_ZERO: begin
				if (fill_q != PAD_LEN_POS) begin
					put_en = 1'b1;
				end else begin
					nxt = ST_LEN;
				end
			end
			ST_LEN: begin
				put_en   = 1'b1;
				put_byte = len_q[63:56];
				nxt      = (lcnt_q == 3'd7) ? ST_OUT : ST_LEN;
			end
			default: ;
		endcase
	end

	assign blk_full = put_en && (fill_q == FILL_LAST);

	always_comb begin
		wr.en      = put_en;
		wr.idx     = fill_q[5:2];
		wr.lane    = fill_q[1:0];
		wr.data    = put_byte;
		rctl.start = blk_full;
		rctl.init  = out_load && (oidx_q == 3'd7);
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ret_q         <= ST_IDLE;
			cnt_q         <= 3'd0;
			last_q        <= 1'b0;
			fill_q        <= 6'd0;
			bitlen_q      <= 64'd0;
			lcnt_q        <= 3'd0;
			oidx_q        <= 3'd0;
			out_valid_q   <= 1'b0;
			digest_last_q <= 1'b0;
			digest_word_q <= 32'd0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (put_en) begin
				fill_q <= fill_q + 6'd1;
				if (blk_full) begin
					state_q <= ST_COMP;
					ret_q   <= nxt;
				end else begin
					state_q <= nxt;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q  <= sat_cnt;
						last_q <= last_word;
						if (sat_cnt != 3'd0) begin
							state_q <= ST_DATA;
						end else if (last_word) begin
							state_q <= ST_MARK;
						end
					end
				end
				ST_DATA: begin
					cnt_q    <= cnt_q - 3'd1;
					bitlen_q <= bitlen_q + 64'd8;
				end
				ST_MARK: begin
					bitlen_q <= 64'd0;
					lcnt_q   <= 3'd0;
				end
				ST_ZERO: begin
					if (!put_en) begin
						state_q <= nxt;
					end
				end
				ST_LEN: begin
					lcnt_q <= lcnt_q + 3'd1;
				end
				ST_COMP: begin
					if (rstat.done) begin
						state_q <= ret_q;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						digest_word_q <= cv_word;
						digest_last_q <= (oidx_q == 3'd7);
						oidx_q        <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			word_q <= data_word;
		end else if (state_q == ST_DATA) begin
			word_q <= word_q << 8;
		end
		if (state_q == ST_MARK) begin
			len_q <= bitlen_q;
		end else if (state_q == ST_LEN) begin
			len_q <= len_q << 8;
		end
	end

	sm3_msg u_msg (
		.clk   (clk),
		.wr    (wr),
		.shift (rstat.shift),
		.w_j   (w_j),
		.wp_j  (wp_j)
	);

	sm3_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (rctl),
		.w_j     (w_j),
		.wp_j    (wp_j),
		.cv_sel  (oidx_q),
		.cv_word (cv_word),
		.stat    (rstat)
	);

	assign out_valid   = out_valid_q;
	assign digest_word = digest_word_q;
	assign digest_last = digest_last_q;

endmodule

/* rtl/sm3_msg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3 message window
// Block buffer filled a byte at a time; during compression it shifts as the
// sixteen-word expansion window and feeds W and W' to the round unit.
// ----------------------------------------------------------------------------
module sm3_msg
	import sm3_pkg::*;
(
	input  logic        clk,
	input  sm3_wr_t     wr,
	input  logic        shift,
	output logic [31:0] w_j,
	output logic [31:0] wp_j
);

	logic [31:0] win_q [16];
	logic [31:0] merged;
	logic [31:0] expand;
	logic [4:0]  sh;

	// byte merge, first byte of a word clears the rest
	always_comb begin
		sh     = {2'd3 - wr.lane, 3'b000};
		merged = ((wr.lane == 2'd0) ? 32'd0 : win_q[wr.idx]) | ({24'd0, wr.data} << sh);
	end

	// next expanded word
	assign expand = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 5'd15))
		^ rotl(win_q[3], 5'd7) ^ win_q[10];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			win_q[wr.idx] <= merged;
		end else if (shift) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= expand;
		end
	end

	assign w_j  = win_q[0];
	assign wp_j = win_q[0] ^ win_q[4];

endmodule

/* rtl/sm3_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3 round unit
// One compression round per cycle for all 64 rounds, then a fold into the
// chaining value; also holds the chaining value for digest readout.
// ----------------------------------------------------------------------------
module sm3_round
	import sm3_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sm3_rctl_t   ctl,
	input  logic [31:0] w_j,
	input  logic [31:0] wp_j,
	input  logic [2:0]  cv_sel,
	output logic [31:0] cv_word,
	output sm3_rst_t    stat
);

	typedef enum logic [1:0] {R_IDLE, R_RUN, R_FOLD} rstate_t;

	rstate_t     state_q;
	logic [5:0]  j_q;
	logic [31:0] cv_q [8];
	logic [31:0] v_q [8];
	logic [31:0] a12, ss, s1, s2, ff, gg, t1, t2;

	// round function
	always_comb begin
		a12 = rotl(v_q[0], 5'd12);
		ss  = a12 + v_q[4] + t_rot(j_q);
		s1  = rotl(ss, 5'd7);
		s2  = s1 ^ a12;
		if (j_q[5:4] == 2'b00) begin
			ff = v_q[0] ^ v_q[1] ^ v_q[2];
			gg = v_q[4] ^ v_q[5] ^ v_q[6];
		end else begin
			ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
			gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
		end
		t1 = ff + v_q[3] + s2 + wp_j;
		t2 = gg + v_q[7] + s1 + w_j;
	end

	// sequencer and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			j_q     <= 6'd0;
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= SM3_IV[i];
			end
		end else begin
			case (state_q)
				R_IDLE: begin
					j_q <= 6'd0;
					if (ctl.start) begin
						state_q <= R_RUN;
					end else if (ctl.init) begin
						for (int i = 0; i < 8; i++) begin
							cv_q[i] <= SM3_IV[i];
						end
					end
				end
				R_RUN: begin
					j_q <= j_q + 6'd1;
					if (j_q == 6'd63) begin
						state_q <= R_FOLD;
					end
				end
				R_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						cv_q[i] <= cv_q[i] ^ v_q[i];
					end
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	// working variables a to h
	always_ff @(posedge clk) begin
		if (state_q == R_IDLE && ctl.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= cv_q[i];
			end
		end else if (state_q == R_RUN) begin
			v_q[0] <= t1;
			v_q[1] <= v_q[0];
			v_q[2] <= rotl(v_q[1], 5'd9);
			v_q[3] <= v_q[2];
			v_q[4] <= perm0(t2);
			v_q[5] <= v_q[4];
			v_q[6] <= rotl(v_q[5], 5'd19);
			v_q[7] <= v_q[6];
		end
	end

	assign cv_word    = cv_q[cv_sel];
	assign stat.shift = (state_q == R_RUN);
	assign stat.done  = (state_q == R_FOLD);

endmodule

/* rtl/sm3_hash_unit_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3 hash unit checker
// Port-level checks on item ordering and digest framing, bound to the top.
// ----------------------------------------------------------------------------
module sm3_hash_unit_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  byte_count,
	input logic        last_word,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic        digest_last
);

	logic [2:0] ocnt_q;
	logic       pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// digest words delivered, modulo eight, and message awaiting its digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 3'd0;
			pend_q <= 1'b0;
		end else begin
			if (out_acc) begin
				ocnt_q <= ocnt_q + 3'd1;
			end
			if (in_acc && last_word) begin
				pend_q <= 1'b1;
			end else if (out_acc && digest_last) begin
				pend_q <= 1'b0;
			end
		end
	end

	// stalled digest word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(digest_last))
		else $error("digest word changed while stalled");

	// an accepted item with valid bytes or last_word set makes the block busy in the next cycle
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (byte_count != 3'd0 || last_word) |=> in_stall)
		else $error("block free right after taking an item");

	// digest_last exactly on every eighth word
	a_last_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digest_last == (ocnt_q == 3'd7))
		else $error("digest_last out of step with word count");

	// no new item until the digest of a finished message is complete
	a_no_item_early: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !(out_valid && digest_last) |-> in_stall)
		else $error("item taken before digest finished");

endmodule

bind sm3_hash_unit sm3_hash_unit_chk u_chk (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3 hash unit testbench
// Streams directed and random messages into the hash unit, works out every
// digest word with a behavioural SM3 of its own and checks the output stream
// word by word, with random idling on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
	import sm3_pkg::*;

	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 7;
	localparam int TARGET_ITEMS    = 410;
	localparam int IDLE_LIMIT      = 6000;
	localparam int DRAIN_CYCLES    = 300;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int PRESSURE_AFTER  = 1000;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  count;
		logic        last;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_t;

	typedef enum int unsigned {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic        digest_last;

	msg_item_t pending_items [$];
	digest_t   digest_fifo [$];
	int        error_count = 0;

	// predicted hash state
	logic [31:0] chain_val [8];
	logic [31:0] msg_block [16];
	logic [63:0] msg_bits;
	int unsigned block_bytes;

	sm3_hash_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.last_word   (last_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.digest_last (digest_last)
	);

	// clock
	always #HALF_PERIOD clk = ~clk;

	function automatic logic [31:0] rotl_word(input logic [31:0] x, input int unsigned n);
		int unsigned s;
		s = n % 32;
		if (s == 0)
			return x;
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic logic [31:0] mix_p0(input logic [31:0] x);
		return x ^ rotl_word(x, 9) ^ rotl_word(x, 17);
	endfunction

	function automatic logic [31:0] mix_p1(input logic [31:0] x);
		return x ^ rotl_word(x, 15) ^ rotl_word(x, 23);
	endfunction

	function automatic void hash_state_reset();
		for (int k = 0; k < 8; k++)
			chain_val[k] = SM3_IV[k];
		msg_bits = '0;
		block_bytes = 0;
	endfunction

	// message expansion and 64 rounds over the full block
	function automatic void sm3_compress();
		logic [31:0] w [68];
		logic [31:0] wx [64];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 16; j++)
			w[j] = msg_block[j];
		for (int j = 16; j < 68; j++)
			w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rotl_word(w[j-3], 15))
				^ rotl_word(w[j-13], 7) ^ w[j-6];
		for (int j = 0; j < 64; j++)
			wx[j] = w[j] ^ w[j+4];
		a = chain_val[0]; b = chain_val[1]; c = chain_val[2]; d = chain_val[3];
		e = chain_val[4]; f = chain_val[5]; g = chain_val[6]; h = chain_val[7];
		for (int j = 0; j < 64; j++) begin
			tj  = (j < 16) ? SM3_T_LO : SM3_T_HI;
			a12 = rotl_word(a, 12);
			ss1 = rotl_word(a12 + e + rotl_word(tj, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			tt1 = ff + d + ss2 + wx[j];
			tt2 = gg + h + ss1 + w[j];
			d = c; c = rotl_word(b, 9); b = a; a = tt1;
			h = g; g = rotl_word(f, 19); f = e; e = mix_p0(tt2);
		end
		chain_val[0] ^= a; chain_val[1] ^= b; chain_val[2] ^= c; chain_val[3] ^= d;
		chain_val[4] ^= e; chain_val[5] ^= f; chain_val[6] ^= g; chain_val[7] ^= h;
	endfunction

	// one byte into the block, compressing when it is full
	function automatic void sm3_put_byte(input logic [7:0] b);
		int unsigned idx;
		int unsigned sh;
		idx = block_bytes / 4;
		sh  = (3 - block_bytes % 4) * 8;
		if (block_bytes % 4 == 0)
			msg_block[idx] = '0;
		msg_block[idx] |= 32'(b) << sh;
		block_bytes++;
		if (block_bytes == 64) begin
			sm3_compress();
			block_bytes = 0;
		end
	endfunction

	// expected digest words for one accepted item
	function automatic void sm3_absorb_item(input logic [31:0] data, input logic [2:0] count,
		input logic last);
		int unsigned n;
		logic [63:0] len;
		digest_t     dw;
		n = (count > 3'd4) ? 4 : count;
		for (int i = 0; i < n; i++) begin
			sm3_put_byte(8'(data >> (24 - 8 * i)));
			msg_bits += 64'd8;
		end
		if (last) begin
			len = msg_bits;
			sm3_put_byte(PAD_MARK);
			while (block_bytes != PAD_LEN_POS)
				sm3_put_byte(8'h00);
			for (int i = 0; i < 8; i++)
				sm3_put_byte(8'(len >> (56 - 8 * i)));
			for (int k = 0; k < 8; k++) begin
				dw.word = chain_val[k];
				dw.last = (k == 7);
				digest_fifo.insert(digest_fifo.size(), dw);
			end
			hash_state_reset();
		end
	endfunction

	function automatic void add_item(input logic [31:0] data, input logic [2:0] count,
		input logic last);
		msg_item_t it;
		it.data  = data;
		it.count = count;
		it.last  = last;
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic logic [31:0] pick_data();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// a message of random content; messy ones carry short, empty or oversized counts
	function automatic void queue_message(input int n_words, input bit messy);
		for (int i = 0; i < n_words; i++)
			add_item(pick_data(), messy ? 3'($urandom_range(0, 7)) : 3'd4, 1'b0);
		add_item(pick_data(), 3'($urandom_range(0, messy ? 7 : 4)), 1'b1);
	endfunction

	// stimulus, reset and end of run
	initial begin
		int sel;
		int n_words;
		hash_state_reset();
		for (int k = 0; k < 16; k++)
			msg_block[k] = '0;

		// empty message, "abc", all ones, oversized count on a single item
		add_item(32'h00000000, 3'd0, 1'b1);
		add_item(32'h61626300, 3'd3, 1'b1);
		add_item(32'hffffffff, 3'd4, 1'b1);
		add_item(32'h00000000, 3'd7, 1'b1);
		// short and empty words mid-message, ending on an empty last item
		add_item(32'ha5a5a5a5, 3'd2, 1'b0);
		add_item(32'hffffffff, 3'd5, 1'b0);
		add_item(32'h12345678, 3'd1, 1'b0);
		add_item(32'h00000000, 3'd0, 1'b0);
		add_item(32'hdeadbeef, 3'd6, 1'b0);
		add_item(32'hcafef00d, 3'd0, 1'b1);
		// 56 bytes, so the padding spills into a second block
		for (int i = 0; i < 13; i++)
			add_item($urandom, 3'd4, 1'b0);
		add_item(32'hffffffff, 3'd4, 1'b1);

		// random messages, mostly short, some across several blocks
		while (pending_items.size() < TARGET_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 50)
				n_words = $urandom_range(0, 8);
			else if (sel < 85)
				n_words = $urandom_range(9, 20);
			else
				n_words = $urandom_range(21, 40);
			queue_message(n_words, $urandom_range(0, 3) == 0);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (digest_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// sender: bursts of items with random gaps
	int        burst_left = 0;
	int        gap_left = 0;
	msg_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				sm3_absorb_item(data_word, byte_count, last_word);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || pending_items.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					next_item = pending_items.pop_front();
					in_valid   <= 1'b1;
					data_word  <= next_item.data;
					byte_count <= next_item.count;
					last_word  <= next_item.last;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end
			end
		end
	end

	// receiver: stall pattern picked at random from four modes, plus long hold-offs
	int unsigned rx_cycle = 0;
	int unsigned hold_left = 0;
	bit          pressure_done = 1'b0;
	rx_mode_t    rx_mode = RX_FREE;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 700 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (hold_left == 0 && out_valid
				&& ((!pressure_done && rx_cycle > PRESSURE_AFTER) || $urandom_range(0, 2999) == 0)) begin
				hold_left     = HOLD_OFF_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (rx_mode)
					RX_FREE:     out_stall <= 1'b0;
					RX_RANDOM:   out_stall <= ($urandom_range(0, 99) < 40);
					RX_PERIODIC: out_stall <= (rx_cycle % 8 >= 5);
					default:     out_stall <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	// checker on the digest stream
	digest_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (digest_fifo.size() == 0) begin
				$display("%0t: digest word %h last %b with none expected",
					$time, digest_word, digest_last);
				error_count++;
			end else begin
				want = digest_fifo.pop_front();
				if (digest_word !== want.word) begin
					$display("%0t: digest_word expected %h actual %h",
						$time, want.word, digest_word);
					error_count++;
				end
				if (digest_last !== want.last) begin
					$display("%0t: digest_last expected %b actual %b",
						$time, want.last, digest_last);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

endmodule
